// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the detector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define LBSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LBSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lbsd_pkg.sv -----
// types and constants of the login burst source detector
package lbsd_pkg;

  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 32;
  localparam int GAP_CFG_W  = 16;
  localparam int MIN_CFG_W  = 8;
  localparam int MEAN_CFG_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ATTEMPTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MEAN_GAP = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_NEW     = 2'd1,
    ST_FLAGGED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // shared adder operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        carry;  // carry out; for a subtract, set when a >= b
    logic        zero;
  } alu_rsp_t;

  // source tag word: valid bit and address
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } tag_t;

  // per-source history
  typedef struct packed {
    logic [TIME_W-1:0]  last_time;
    logic [COUNT_W-1:0] attempts;
    logic [SUM_W-1:0]   gap_sum;
  } rec_t;

endpackage

// ----- rtl/core/lbsd_alu.sv -----
// shared 32-bit add / subtract unit with carry and zero flags
module lbsd_alu
  import lbsd_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [31:0] b_eff;
  logic [32:0] sum;

  assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, (req.op == ALU_SUB)};

  assign rsp.res   = sum[31:0];
  assign rsp.carry = sum[32];
  assign rsp.zero  = (sum[31:0] == 32'd0);

endmodule

// ----- rtl/core/lbsd_table.sv -----
// source table: tag memory and history memory, one write and one read port each
module lbsd_table
  import lbsd_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          tag_we,
  input  logic [AW-1:0] tag_waddr,
  input  tag_t          tag_wdata,
  input  logic [AW-1:0] tag_raddr,
  output tag_t          tag_rdata,
  input  logic          rec_we,
  input  logic [AW-1:0] rec_waddr,
  input  rec_t          rec_wdata,
  input  logic [AW-1:0] rec_raddr,
  output rec_t          rec_rdata
);

  tag_t tag_mem [DEPTH];
  rec_t rec_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rdata <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata <= rec_mem[rec_raddr];
  end

endmodule

// ----- rtl/core/login_burst_source_detector.sv -----
// top level of the login burst source detector: sequencer, registers and result stage
// Each accepted transaction is one failed-login event (time, IPv4 source) and gives
// exactly one result transaction: status 0 updated, 1 new entry, 2 flagged and freed,
// 3 table full and dropped, with the source address and its attempt count. After reset
// the block runs a clearing pass over every entry of the tag memory and takes
// no events meanwhile (configuration writes are taken). From acceptance to a valid
// result an event goes through a linear scan of the tag memory through its single
// read port, one entry per cycle, followed by a handful of steps through one shared
// 32-bit adder for the gap, reset test, sum, count and flag compare, as the case
// needs. The input is not ready while an event is in work; the result sits in an
// output register, so the next event can be taken in the cycle after the result is
// loaded while that result waits.
module login_burst_source_detector
  import lbsd_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // event stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // event_time [31:0], source_address [63:32]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata    // status [1:0], flagged_address [33:2],
                                           // attempt_count [49:34], zero [55:50]
);

`include "assert_macros.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LOOKUP,
    S_GAP,
    S_AGE,
    S_SUM,
    S_INC,
    S_MUL,
    S_CSUM,
    S_WRITE,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [GAP_CFG_W-1:0]  reset_gap;
  logic [MIN_CFG_W-1:0]  min_attempts;
  logic [MEAN_CFG_W-1:0] max_mean_gap;

  // event being worked on
  logic [TIME_W-1:0]  ev_time;
  logic [ADDR_W-1:0]  ev_addr;

  // scan results
  logic [CW-1:0] cnt;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic [AW-1:0] tgt_idx;

  // working copy of the source history
  logic [COUNT_W-1:0] attempts;
  logic [SUM_W-1:0]   gap_sum;
  logic [TIME_W-1:0]  gap;
  logic [SUM_W-1:0]   product;
  logic               count_ok;
  status_t            status;

  // memory ports
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  tag_t          tag_wdata;
  logic [AW-1:0] tag_raddr;
  tag_t          tag_rdata;
  logic          rec_we;
  rec_t          rec_wdata;
  rec_t          rec_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] eval_idx;

  lbsd_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (tag_wdata),
    .tag_raddr (tag_raddr),
    .tag_rdata (tag_rdata),
    .rec_we    (rec_we),
    .rec_waddr (tgt_idx),
    .rec_wdata (rec_wdata),
    .rec_raddr (hit_idx),
    .rec_rdata (rec_rdata)
  );

  lbsd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign s_tready = (state == S_IDLE);

  // entry whose tag word comes back from the memory this cycle
  assign cnt_m1   = cnt - CW'(1);
  assign eval_idx = cnt_m1[AW-1:0];

  // scan read address walks the table; stays in range on the final compare cycle
  assign tag_raddr = (cnt < CW'(TABLE_DEPTH)) ? cnt[AW-1:0] : '0;

  // tag writes: clearing pass after reset, else the update of the chosen entry
  always_comb begin
    tag_we          = 1'b0;
    tag_waddr       = tgt_idx;
    tag_wdata.valid = (status != ST_FLAGGED);
    tag_wdata.addr  = ev_addr;
    if (state == S_CLEAR) begin
      tag_we    = 1'b1;
      tag_waddr = cnt[AW-1:0];
      tag_wdata = '0;
    end else if (state == S_WRITE) begin
      tag_we = 1'b1;
    end
  end

  assign rec_we              = (state == S_WRITE);
  assign rec_wdata.last_time = ev_time;
  assign rec_wdata.attempts  = attempts;
  assign rec_wdata.gap_sum   = gap_sum;

  // operand select for the shared adder, one use per sequencer step
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = tag_rdata.addr;
    alu_req.b  = ev_addr;
    case (state)
      S_GAP: begin
        alu_req.a = ev_time;
        alu_req.b = rec_rdata.last_time;
      end
      S_AGE: begin
        alu_req.a = gap;
        alu_req.b = {16'd0, reset_gap};
      end
      S_SUM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = gap_sum;
        alu_req.b  = gap;
      end
      S_INC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {16'd0, attempts};
        alu_req.b  = 32'd1;
      end
      S_MUL: begin
        alu_req.a = {16'd0, attempts};
        alu_req.b = {24'd0, min_attempts};
      end
      S_CSUM: begin
        alu_req.a = product;
        alu_req.b = gap_sum;
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      hit_found    <= 1'b0;
      free_found   <= 1'b0;
      m_tvalid     <= 1'b0;
      reset_gap    <= 16'd900;
      min_attempts <= 8'd10;
      max_mean_gap <= 16'd30;
      status       <= ST_UPDATED;
    end else begin
      // configuration writes, unknown indexes ignored
      if (cfg_we) begin
        case (cfg_index)
          REG_RESET_GAP:    reset_gap    <= cfg_data[GAP_CFG_W-1:0];
          REG_MIN_ATTEMPTS: min_attempts <= cfg_data[MIN_CFG_W-1:0];
          REG_MAX_MEAN_GAP: max_mean_gap <= cfg_data[MEAN_CFG_W-1:0];
          default: ;
        endcase
      end

      // result register drains independently of the sequencer; S_OUT reloads it itself
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (cnt == CW'(TABLE_DEPTH - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end

        S_IDLE: begin
          if (s_tvalid) begin
            ev_time    <= s_tdata[31:0];
            ev_addr    <= s_tdata[63:32];
            cnt        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end

        // one tag compare per cycle, lowest matching and lowest free entry kept
        S_SCAN: begin
          if (cnt != '0) begin
            if (tag_rdata.valid) begin
              if (!hit_found && alu_rsp.zero) begin
                hit_found <= 1'b1;
                hit_idx   <= eval_idx;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= eval_idx;
            end
          end
          if (cnt == CW'(TABLE_DEPTH)) begin
            state <= S_LOOKUP;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end

        // history of a hit is read here (address is hit_idx)
        S_LOOKUP: begin
          if (hit_found) begin
            tgt_idx <= hit_idx;
            state   <= S_GAP;
          end else if (free_found) begin
            tgt_idx  <= free_idx;
            attempts <= COUNT_W'(1);
            gap_sum  <= '0;
            status   <= ST_NEW;
            state    <= S_MUL;
          end else begin
            attempts <= '0;
            status   <= ST_FULL;
            state    <= S_OUT;
          end
        end

        // backward time step counts as zero gap
        S_GAP: begin
          gap      <= alu_rsp.carry ? alu_rsp.res : '0;
          attempts <= rec_rdata.attempts;
          gap_sum  <= rec_rdata.gap_sum;
          status   <= ST_UPDATED;
          state    <= S_AGE;
        end

        // long gap clears the history
        S_AGE: begin
          if (alu_rsp.carry) begin
            attempts <= '0;
            gap_sum  <= '0;
            state    <= S_INC;
          end else begin
            state <= S_SUM;
          end
        end

        S_SUM: begin
          gap_sum <= alu_rsp.carry ? '1 : alu_rsp.res;
          state   <= S_INC;
        end

        S_INC: begin
          attempts <= alu_rsp.res[16] ? '1 : alu_rsp.res[15:0];
          state    <= S_MUL;
        end

        // product registered; count test shares the cycle
        S_MUL: begin
          product  <= {16'd0, max_mean_gap} * {16'd0, attempts};
          count_ok <= alu_rsp.carry;
          state    <= S_CSUM;
        end

        S_CSUM: begin
          if (count_ok && alu_rsp.carry) begin
            status <= ST_FLAGGED;
          end
          state <= S_WRITE;
        end

        S_WRITE: begin
          state <= S_OUT;
        end

        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, attempts, ev_addr, status};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result field views for checking
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_count;

  assign out_status = m_tdata[1:0];
  assign out_count  = m_tdata[49:34];

  `LBSD_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready,
    "input still ready right after an accepted transaction")
  `LBSD_ASSERT_IMP(a_full_zero_count, clk, rst, m_tvalid && (out_status == ST_FULL),
    out_count == '0, "dropped event reports a nonzero count")
  `LBSD_ASSERT_IMP(a_new_count_one, clk, rst, m_tvalid && (out_status == ST_NEW),
    out_count == COUNT_W'(1), "new entry reports a count other than one")
  `LBSD_ASSERT_IMP(a_scan_bound, clk, rst, state == S_SCAN, cnt <= CW'(TABLE_DEPTH),
    "scan counter ran past the table")

endmodule
